/* hdl/keyword_operator_lexer_macros.svh */
// ---------------------------------------------------------------------------
// keyword_operator_lexer assertion macros
// Shorthand for clocked assertions with reset disable, used by the checker.
// ---------------------------------------------------------------------------
`ifndef KEYWORD_OPERATOR_LEXER_MACROS_SVH
`define KEYWORD_OPERATOR_LEXER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define KLEX_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define KLEX_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/klex_pkg.sv */
// ---------------------------------------------------------------------------
// klex_pkg
// Shared types, codes, character constants and keyword tables of the lexer.
// ---------------------------------------------------------------------------
`default_nettype none

package klex_pkg;

  localparam int TEXT_MAX_DEF   = 262144;
  localparam int MAX_LEXEME_DEF = 256;
  localparam int BUF_DEPTH_DEF  = 4;

  localparam int CHAR_W   = 8;
  localparam int CODE_W   = 6;
  localparam int START_W  = 18;
  localparam int LENGTH_W = 8;
  localparam int NKW      = 4;

  typedef enum logic [CODE_W-1:0] {
    TOK_EQUAL  = 6'd1,
    TOK_COMMA  = 6'd2,
    TOK_LPAREN = 6'd3,
    TOK_RPAREN = 6'd4,
    TOK_SEMI   = 6'd7,
    TOK_LBRACE = 6'd8,
    TOK_RBRACE = 6'd9,
    TOK_WHILE  = 6'd12,
    TOK_RETURN = 6'd13,
    TOK_TYPE   = 6'd17,
    TOK_BINOP  = 6'd22,
    TOK_NUMBER = 6'd51,
    TOK_IDENT  = 6'd55
  } tok_code_e;

  typedef enum logic [1:0] {
    WM_NONE   = 2'd0,
    WM_IDENT  = 2'd1,
    WM_NUMBER = 2'd2
  } word_mode_e;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_EQ   = 2'd1,
    PEND_BANG = 2'd2
  } pend_e;

  localparam logic [1:0] KW_WHILE  = 2'd0;
  localparam logic [1:0] KW_RETURN = 2'd1;
  localparam logic [1:0] KW_INT    = 2'd2;
  localparam logic [1:0] KW_VOID   = 2'd3;

  localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_W-1:0] CH_BANG   = 8'h21;
  localparam logic [CHAR_W-1:0] CH_PCT    = 8'h25;
  localparam logic [CHAR_W-1:0] CH_LPAREN = 8'h28;
  localparam logic [CHAR_W-1:0] CH_RPAREN = 8'h29;
  localparam logic [CHAR_W-1:0] CH_STAR   = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
  localparam logic [CHAR_W-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_W-1:0] CH_EQ     = 8'h3D;
  localparam logic [CHAR_W-1:0] CH_LBRACE = 8'h7B;
  localparam logic [CHAR_W-1:0] CH_RBRACE = 8'h7D;

  // Keyword spelling, padded with zero bytes.
  localparam logic [CHAR_W-1:0] KW_TEXT [NKW][8] = '{
    '{"w", "h", "i", "l", "e", 8'h00, 8'h00, 8'h00},
    '{"r", "e", "t", "u", "r", "n", 8'h00, 8'h00},
    '{"i", "n", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"v", "o", "i", "d", 8'h00, 8'h00, 8'h00, 8'h00}
  };

  // Field order from the lowest bit up: code, start, length, overlong, last.
  typedef struct packed {
    logic                  last;
    logic                  overlong;
    logic [LENGTH_W-1:0]   length;
    logic [START_W-1:0]    start;
    tok_code_e             code;
  } token_t;

  typedef struct packed {
    logic   v1;
    token_t tok1;
    logic   v0;
    token_t tok0;
  } tok_pair_t;

  typedef struct packed {
    logic      valid;
    tok_code_e code;
  } punct_t;

  function automatic logic is_alpha(input logic [CHAR_W-1:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
  endfunction

  function automatic logic is_digit(input logic [CHAR_W-1:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic [CHAR_W-1:0] kw_char(input logic [1:0] k, input logic [2:0] i);
    return KW_TEXT[k][i];
  endfunction

  function automatic logic [2:0] kw_len(input logic [1:0] k);
    logic [2:0] len;
    unique case (k)
      KW_WHILE:  len = 3'd5;
      KW_RETURN: len = 3'd6;
      KW_INT:    len = 3'd3;
      default:   len = 3'd4;
    endcase
    return len;
  endfunction

  function automatic tok_code_e kw_code(input logic [1:0] k);
    tok_code_e code;
    unique case (k)
      KW_WHILE:  code = TOK_WHILE;
      KW_RETURN: code = TOK_RETURN;
      default:   code = TOK_TYPE;
    endcase
    return code;
  endfunction

  function automatic punct_t punct_decode(input logic [CHAR_W-1:0] c);
    punct_t p;
    p.valid = 1'b1;
    unique case (c) inside
      CH_LPAREN:               p.code = TOK_LPAREN;
      CH_RPAREN:               p.code = TOK_RPAREN;
      CH_LBRACE:               p.code = TOK_LBRACE;
      CH_RBRACE:               p.code = TOK_RBRACE;
      CH_COMMA:                p.code = TOK_COMMA;
      CH_SEMI:                 p.code = TOK_SEMI;
      CH_PLUS, CH_STAR, CH_PCT: p.code = TOK_BINOP;
      default: begin
        p.valid = 1'b0;
        p.code  = TOK_BINOP;
      end
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

/* hdl/klex_core.sv */
// ---------------------------------------------------------------------------
// klex_core
// Lexer state and single-pass token decode for one registered text byte.
// ---------------------------------------------------------------------------
`default_nettype none

module klex_core #(
  parameter int TEXT_MAX   = klex_pkg::TEXT_MAX_DEF,
  parameter int MAX_LEXEME = klex_pkg::MAX_LEXEME_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        fire_i,
  input  logic [klex_pkg::CHAR_W-1:0] char_i,
  output klex_pkg::tok_pair_t         pair_o
);
  import klex_pkg::*;

  localparam int POS_W = $clog2(TEXT_MAX);
  localparam int LEN_W = $clog2(MAX_LEXEME + 1);
  localparam int LIM   = (MAX_LEXEME - 1 > 255) ? 255 : MAX_LEXEME - 1;
  localparam int EXT_W = (POS_W > START_W) ? POS_W : START_W;

  word_mode_e       mode_q, mode_d;
  pend_e            pend_q, pend_d;
  logic [NKW-1:0]   cand_q, cand_d;
  logic [POS_W-1:0] wstart_q, wstart_d;
  logic [LEN_W-1:0] wlen_q, wlen_d;
  logic [POS_W-1:0] pos_q, pos_d;

  logic [POS_W-1:0] pos_next, pos_prev;
  logic [EXT_W-1:0] pos_ext, prev_ext, wstart_ext;
  logic             is_end, alpha, digit, word_open;
  logic             form_two, extend, close_word, eq_emit, punct_emit, first_valid;
  punct_t           punct;
  logic             word_over;
  tok_code_e        word_code;
  logic [NKW-1:0]   cand_ext, cand_open;
  token_t           word_tok, eq_tok, binop_tok, punct_tok, first_tok;

  assign pos_next = (pos_q == POS_W'(TEXT_MAX - 1)) ? '0 : pos_q + 1'b1;
  assign pos_prev = (pos_q == '0) ? POS_W'(TEXT_MAX - 1) : pos_q - 1'b1;
  assign pos_ext    = EXT_W'(pos_q);
  assign prev_ext   = EXT_W'(pos_prev);
  assign wstart_ext = EXT_W'(wstart_q);

  assign is_end    = (char_i == CH_NUL);
  assign alpha     = is_alpha(char_i);
  assign digit     = is_digit(char_i);
  assign punct     = punct_decode(char_i);
  assign word_open = (mode_q == WM_IDENT) || (mode_q == WM_NUMBER);

  assign form_two   = !is_end && (pend_q != PEND_NONE) && (char_i == CH_EQ);
  assign extend     = !is_end && !form_two &&
                      (((mode_q == WM_IDENT) && (alpha || digit)) ||
                       ((mode_q == WM_NUMBER) && digit));
  assign close_word = word_open && (is_end || (!form_two && !extend));
  assign eq_emit    = (pend_q == PEND_EQ) && !form_two && !close_word;
  assign punct_emit = !is_end && !form_two && !extend && punct.valid;
  assign first_valid = close_word || eq_emit;

  // Keyword match against whole-word length and surviving prefix candidates.
  always_comb begin
    word_code = (mode_q == WM_NUMBER) ? TOK_NUMBER : TOK_IDENT;
    for (int k = 0; k < NKW; k++) begin
      if (mode_q == WM_IDENT && cand_q[k] && wlen_q == LEN_W'(kw_len(2'(k))))
        word_code = kw_code(2'(k));
    end
  end

  always_comb begin
    for (int k = 0; k < NKW; k++) begin
      cand_ext[k]  = cand_q[k] && (wlen_q < LEN_W'(kw_len(2'(k)))) &&
                     (kw_char(2'(k), wlen_q[2:0]) == char_i);
      cand_open[k] = (kw_char(2'(k), 3'd0) == char_i);
    end
  end

  assign word_over = (wlen_q > LEN_W'(LIM));

  always_comb begin
    word_tok.code     = word_code;
    word_tok.start    = wstart_ext[START_W-1:0];
    word_tok.length   = word_over ? LENGTH_W'(LIM) : LENGTH_W'(wlen_q);
    word_tok.overlong = word_over;
    word_tok.last     = 1'b0;

    eq_tok.code     = TOK_EQUAL;
    eq_tok.start    = prev_ext[START_W-1:0];
    eq_tok.length   = LENGTH_W'(1);
    eq_tok.overlong = 1'b0;
    eq_tok.last     = 1'b0;

    binop_tok        = eq_tok;
    binop_tok.code   = TOK_BINOP;
    binop_tok.length = LENGTH_W'(2);
    binop_tok.last   = 1'b1;

    punct_tok.code     = punct.code;
    punct_tok.start    = pos_ext[START_W-1:0];
    punct_tok.length   = LENGTH_W'(1);
    punct_tok.overlong = 1'b0;
    punct_tok.last     = 1'b1;

    first_tok = close_word ? word_tok : eq_tok;
  end

  // Token output: compact the two possible tokens into slot order.
  always_comb begin
    pair_o = '0;
    if (form_two) begin
      pair_o.v0   = fire_i;
      pair_o.tok0 = binop_tok;
    end else begin
      pair_o.v0        = fire_i && (first_valid || punct_emit);
      pair_o.tok0      = first_valid ? first_tok : punct_tok;
      pair_o.tok0.last = !(first_valid && punct_emit);
      pair_o.v1        = fire_i && first_valid && punct_emit;
      pair_o.tok1      = punct_tok;
    end
  end

  // Next state.
  always_comb begin
    mode_d   = mode_q;
    pend_d   = pend_q;
    cand_d   = cand_q;
    wstart_d = wstart_q;
    wlen_d   = wlen_q;
    pos_d    = pos_q;
    if (is_end) begin
      mode_d   = WM_NONE;
      pend_d   = PEND_NONE;
      cand_d   = '0;
      wstart_d = '0;
      wlen_d   = '0;
      pos_d    = '0;
    end else begin
      pend_d = PEND_NONE;
      pos_d  = pos_next;
      if (extend) begin
        cand_d = cand_ext;
        if (wlen_q < LEN_W'(MAX_LEXEME))
          wlen_d = wlen_q + 1'b1;
      end else if (!form_two) begin
        if (close_word) begin
          mode_d = WM_NONE;
          cand_d = '0;
          wlen_d = '0;
        end
        if (char_i == CH_EQ)
          pend_d = PEND_EQ;
        else if (char_i == CH_BANG)
          pend_d = PEND_BANG;
        if (alpha || digit) begin
          mode_d   = alpha ? WM_IDENT : WM_NUMBER;
          wstart_d = pos_q;
          wlen_d   = LEN_W'(1);
          cand_d   = alpha ? cand_open : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= WM_NONE;
      pend_q   <= PEND_NONE;
      cand_q   <= '0;
      wstart_q <= '0;
      wlen_q   <= '0;
      pos_q    <= '0;
    end else if (fire_i) begin
      mode_q   <= mode_d;
      pend_q   <= pend_d;
      cand_q   <= cand_d;
      wstart_q <= wstart_d;
      wlen_q   <= wlen_d;
      pos_q    <= pos_d;
    end
  end

endmodule

`default_nettype wire

/* hdl/klex_fifo.sv */
// ---------------------------------------------------------------------------
// klex_fifo
// Token buffer: takes up to two tokens a cycle, releases one a cycle while out_ready_i is high.
// ---------------------------------------------------------------------------
`default_nettype none

module klex_fifo #(
  parameter int DEPTH = klex_pkg::BUF_DEPTH_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  klex_pkg::tok_pair_t push_i,
  output logic                room_o,
  output logic                out_valid_o,
  output klex_pkg::token_t    out_tok_o,
  input  logic                out_ready_i
);
  import klex_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  token_t           mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign room_o      = (cnt_q <= CNT_W'(DEPTH - 2));
  assign out_valid_o = (cnt_q != '0);
  assign out_tok_o   = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && out_ready_i;
  assign wr_ptr_nx   = ptr_inc(wr_ptr_q);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    if (push_i.v1)
      wr_ptr_d = ptr_inc(wr_ptr_nx);
    else if (push_i.v0)
      wr_ptr_d = wr_ptr_nx;
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    cnt_d    = cnt_q + CNT_W'(push_i.v0) + CNT_W'(push_i.v1) - CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.v0)
      mem_q[wr_ptr_q] <= push_i.tok0;
    if (push_i.v1)
      mem_q[wr_ptr_nx] <= push_i.tok1;
  end

endmodule

`default_nettype wire

/* hdl/keyword_operator_lexer.sv */
// ---------------------------------------------------------------------------
// keyword_operator_lexer
// Byte-stream lexer: identifiers, numbers, keywords and operator tokens.
// ---------------------------------------------------------------------------
// The block takes one text byte per beat and returns tokens as code, start
// offset and length. Identifiers are [a-zA-Z][a-zA-Z0-9]*, numbers [0-9]+;
// while/return/int/void become keyword tokens only as whole words. The
// characters ( ) { } , ; + * % are one-byte tokens, '==' and '!=' are
// two-byte binops, a lone '=' is EQUAL and a lone '!' is dropped. A zero byte
// ends the text: it flushes an open word or pending '=' and restarts the
// offset at zero. Lengths saturate at min(MAX_LEXEME-1, 255) and then raise
// the overlong flag in tuser. One byte yields zero, one or two tokens; tlast
// marks the final token caused by a byte. An accepted byte is held in the
// input register, decoded in a single pass while the buffer has room, and
// its tokens land in a BUF_DEPTH-entry token buffer that drives the master
// side. A byte can be taken every cycle; the input stalls only while the
// buffer holds more than BUF_DEPTH-2 tokens, so the output side, at one
// token per cycle, sets the sustained rate.
`default_nettype none

module keyword_operator_lexer #(
  parameter int TEXT_MAX   = klex_pkg::TEXT_MAX_DEF,
  parameter int MAX_LEXEME = klex_pkg::MAX_LEXEME_DEF,
  parameter int BUF_DEPTH  = klex_pkg::BUF_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Text byte stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] char_code
  // Token stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [5:0] token_code, [23:6] lexeme_start,
                                      // [31:24] lexeme_length
  output logic        m_axis_tuser,   // [0] overlong
  output logic        m_axis_tlast    // last_of_run
);
  import klex_pkg::*;

  logic [CHAR_W-1:0] byte_q, byte_d;
  logic              busy_q, busy_d;
  logic              room, advance, load;
  tok_pair_t         pair;
  token_t            out_tok;

  // Drain the input register whenever the buffer can take two tokens.
  assign advance       = busy_q && room;
  assign s_axis_tready = !busy_q || room;
  assign load          = s_axis_tvalid && s_axis_tready;

  always_comb begin
    byte_d = load ? s_axis_tdata : byte_q;
    busy_d = load ? 1'b1 : (advance ? 1'b0 : busy_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni)
      busy_q <= 1'b0;
    else
      busy_q <= busy_d;
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
  end

  klex_core #(
    .TEXT_MAX   (TEXT_MAX),
    .MAX_LEXEME (MAX_LEXEME)
  ) u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .char_i (byte_q),
    .pair_o (pair)
  );

  klex_fifo #(
    .DEPTH (BUF_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (pair),
    .room_o      (room),
    .out_valid_o (m_axis_tvalid),
    .out_tok_o   (out_tok),
    .out_ready_i (m_axis_tready)
  );

  // Pack the head token onto the master side.
  assign m_axis_tdata = {out_tok.length, out_tok.start, out_tok.code};
  assign m_axis_tuser = out_tok.overlong;
  assign m_axis_tlast = out_tok.last;

endmodule

`default_nettype wire

/* hdl/klex_checker.sv */
// ---------------------------------------------------------------------------
// klex_checker
// Port-level checks on the token stream of the lexer, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none
`include "keyword_operator_lexer_macros.svh"

module klex_checker #(
  parameter int MAX_LEXEME = klex_pkg::MAX_LEXEME_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tuser,
  input logic        m_axis_tlast
);
  import klex_pkg::*;

  localparam int LIM = (MAX_LEXEME - 1 > 255) ? 255 : MAX_LEXEME - 1;

  logic [CODE_W-1:0]   code;
  logic [LENGTH_W-1:0] len;
  logic                in_beat;

  assign code    = m_axis_tdata[5:0];
  assign len     = m_axis_tdata[31:24];
  assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata != CH_NUL);

  `KLEX_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready && !in_beat, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "token changed while stalled")

  `KLEX_ASSERT_NOW(a_overlong_word, m_axis_tvalid && m_axis_tuser, len == LENGTH_W'(LIM) && (code == TOK_IDENT || code == TOK_NUMBER), "overlong flag on a bad token")

  `KLEX_ASSERT_NOW(a_punct_len, m_axis_tvalid && (code == TOK_EQUAL || code == TOK_COMMA || code == TOK_LPAREN || code == TOK_RPAREN || code == TOK_SEMI || code == TOK_LBRACE || code == TOK_RBRACE), len == LENGTH_W'(1) && !m_axis_tuser, "punctuation token not one byte")

  `KLEX_ASSERT_NOW(a_binop_len, m_axis_tvalid && code == TOK_BINOP, len == LENGTH_W'(1) || len == LENGTH_W'(2), "binop token length out of range")

endmodule

bind keyword_operator_lexer klex_checker #(
  .MAX_LEXEME (MAX_LEXEME)
) u_klex_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// keyword_operator_lexer testbench
// Streams text bytes into the lexer and checks every token beat against a
// cycle-free model of the lexer kept in a small scoreboard. The run covers a
// directed text, saturating word lengths and random text under four idling
// mixes on the byte and token sides.
// ---------------------------------------------------------------------------

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import klex_pkg::*;

  // Longest reported lexeme and the saturation point of the word count.
  localparam int LEN_CAP   = (MAX_LEXEME_DEF - 1 > 255) ? 255 : MAX_LEXEME_DEF - 1;
  localparam int LEN_LIMIT = MAX_LEXEME_DEF;

  typedef struct {
    tok_code_e          code;
    logic [START_W-1:0] start;
    logic [7:0]         length;
    logic               overlong;
    logic               last;
  } lex_token_t;

  // Token scoreboard: predicts the tokens of each accepted byte and checks
  // the token beats in order against them.
  class lexer_scoreboard;
    lex_token_t tokens_due[$];
    lex_token_t run_q[$];
    word_mode_e mode;
    pend_e      pend;
    // Offsets are 18 bits wide, so plain vector arithmetic wraps them.
    logic [START_W-1:0] word_start;
    logic [START_W-1:0] text_pos;
    int unsigned        word_len;
    logic [47:0]        word_head;   // first six characters, oldest on top
    int                 errors;

    function new();
      clear();
      errors = 0;
    endfunction

    function void clear();
      mode       = WM_NONE;
      pend       = PEND_NONE;
      word_start = '0;
      text_pos   = '0;
      word_len   = 0;
      word_head  = '0;
    endfunction

    function int pending();
      return tokens_due.size();
    endfunction

    function bit letter(logic [7:0] c);
      return c inside {[8'h41:8'h5A], [8'h61:8'h7A]};
    endfunction

    function bit numeral(logic [7:0] c);
      return c inside {[8'h30:8'h39]};
    endfunction

    function void add(tok_code_e code, logic [START_W-1:0] start, int unsigned len,
                      logic over);
      lex_token_t t;
      t.code     = code;
      t.start    = start;
      t.length   = len[7:0];
      t.overlong = over;
      t.last     = 1'b0;
      run_q.push_back(t);
    endfunction

    function void open_word(word_mode_e m, logic [7:0] c);
      mode       = m;
      word_start = text_pos;
      word_len   = 1;
      word_head  = {40'd0, c};
    endfunction

    function void grow_word(logic [7:0] c);
      if (word_len < 6) word_head = {word_head[39:0], c};
      if (word_len < LEN_LIMIT) word_len++;
    endfunction

    function void close_word();
      tok_code_e   code;
      int unsigned len;
      code = (mode == WM_NUMBER) ? TOK_NUMBER : TOK_IDENT;
      // A keyword only counts as the whole word; words never hold zero bytes,
      // so equal heads mean equal lengths.
      if (mode == WM_IDENT && word_len <= 6) begin
        case (word_head)
          "while":       code = TOK_WHILE;
          "return":      code = TOK_RETURN;
          "int", "void": code = TOK_TYPE;
          default: ;
        endcase
      end
      len = (word_len > LEN_CAP) ? LEN_CAP : word_len;
      add(code, word_start, len, word_len > LEN_CAP);
      mode      = WM_NONE;
      word_len  = 0;
      word_head = '0;
    endfunction

    function void publish();
      if (run_q.size() > 0) run_q[run_q.size()-1].last = 1'b1;
      foreach (run_q[i]) tokens_due.push_back(run_q[i]);
      run_q.delete();
    endfunction

    function void note_byte(logic [7:0] c);
      bit    done;
      pend_e op;
      done = 1'b0;
      run_q.delete();
      if (c == CH_NUL) begin
        // End of text: flush, then start over at offset zero.
        if (mode != WM_NONE) close_word();
        else if (pend == PEND_EQ) add(TOK_EQUAL, text_pos - 18'd1, 1, 1'b0);
        clear();
        publish();
        return;
      end
      if (pend != PEND_NONE) begin
        op   = pend;
        pend = PEND_NONE;
        if (c == CH_EQ) begin
          add(TOK_BINOP, text_pos - 18'd1, 2, 1'b0);
          done = 1'b1;
        end else if (op == PEND_EQ) begin
          add(TOK_EQUAL, text_pos - 18'd1, 1, 1'b0);
        end
      end
      if (!done && mode == WM_IDENT) begin
        if (letter(c) || numeral(c)) begin
          grow_word(c);
          done = 1'b1;
        end else begin
          close_word();
        end
      end else if (!done && mode == WM_NUMBER) begin
        if (numeral(c)) begin
          grow_word(c);
          done = 1'b1;
        end else begin
          close_word();
        end
      end
      if (!done) begin
        case (c)
          CH_LPAREN:                add(TOK_LPAREN, text_pos, 1, 1'b0);
          CH_RPAREN:                add(TOK_RPAREN, text_pos, 1, 1'b0);
          CH_LBRACE:                add(TOK_LBRACE, text_pos, 1, 1'b0);
          CH_RBRACE:                add(TOK_RBRACE, text_pos, 1, 1'b0);
          CH_COMMA:                 add(TOK_COMMA, text_pos, 1, 1'b0);
          CH_SEMI:                  add(TOK_SEMI, text_pos, 1, 1'b0);
          CH_PLUS, CH_STAR, CH_PCT: add(TOK_BINOP, text_pos, 1, 1'b0);
          CH_EQ:                    pend = PEND_EQ;
          CH_BANG:                  pend = PEND_BANG;
          default: begin
            if (letter(c)) open_word(WM_IDENT, c);
            else if (numeral(c)) open_word(WM_NUMBER, c);
          end
        endcase
      end
      text_pos = text_pos + 18'd1;
      publish();
    endfunction

    function void check_token(logic [31:0] data, logic user, logic last);
      lex_token_t want;
      if (tokens_due.size() == 0) begin
        $error("unexpected token beat: tdata %h tuser %b tlast %b", data, user, last);
        errors++;
        return;
      end
      want = tokens_due.pop_front();
      if (data[5:0] !== want.code) begin
        $error("token_code: expected %0d, got %0d", want.code, data[5:0]);
        errors++;
      end
      if (data[23:6] !== want.start) begin
        $error("lexeme_start: expected %0d, got %0d", want.start, data[23:6]);
        errors++;
      end
      if (data[31:24] !== want.length) begin
        $error("lexeme_length: expected %0d, got %0d", want.length, data[31:24]);
        errors++;
      end
      if (user !== want.overlong) begin
        $error("overlong: expected %0b, got %0b", want.overlong, user);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0b, got %0b", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;    // [7:0] char_code
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;    // [5:0] token_code, [23:6] lexeme_start,
                                // [31:24] lexeme_length
  logic        m_axis_tuser;    // [0] overlong
  logic        m_axis_tlast;    // last_of_run

  lexer_scoreboard lexer_sb = new();

  int    src_idle_pct   = 0;
  int    sink_stall_pct = 0;
  int    bytes_sent     = 0;
  string keyword_words[4] = '{"while", "return", "int", "void"};
  string punct_chars      = "(){},;+*%";

  keyword_operator_lexer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #6 clk_i = ~clk_i;

  // Stall the token side at the rate of the current phase.
  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Sample both handshakes with the values they held before the edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) lexer_sb.note_byte(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready)
        lexer_sb.check_token(m_axis_tdata, m_axis_tuser, m_axis_tlast);
    end
  end

  // Offer one byte, with random idle cycles ahead of it; return at its beat.
  task automatic send_byte(input logic [7:0] c);
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= c;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] pick_letter();
    int r;
    r = $urandom_range(51);
    return (r < 26) ? 8'(65 + r) : 8'(71 + r);
  endfunction

  function automatic logic [7:0] pick_alnum();
    int r;
    r = $urandom_range(61);
    if (r < 10) return 8'(48 + r);
    if (r < 36) return 8'(55 + r);
    return 8'(61 + r);
  endfunction

  function automatic logic [7:0] pick_digit();
    return 8'(48 + $urandom_range(9));
  endfunction

  task automatic send_word(input int len, input bit numeric);
    send_byte(numeric ? pick_digit() : pick_letter());
    repeat (len - 1) send_byte(numeric ? pick_digit() : pick_alnum());
  endtask

  // One random piece of text: mostly well-formed tokens, some noise.
  task automatic send_snippet();
    int    kind;
    int    n;
    int    i;
    string word;
    kind = $urandom_range(99);
    if (kind < 14) begin
      send_text(keyword_words[$urandom_range(3)]);
    end else if (kind < 22) begin
      // Near miss: a keyword prefix, or a keyword run on by one more character.
      word = keyword_words[$urandom_range(3)];
      if ($urandom_range(1)) begin
        n = $urandom_range(1, word.len() - 1);
        for (i = 0; i < n; i++) send_byte(word[i]);
      end else begin
        send_text(word);
        send_byte(pick_alnum());
      end
    end else if (kind < 36) begin
      send_byte(pick_letter());
      repeat ($urandom_range(8)) send_byte(pick_alnum());
    end else if (kind < 46) begin
      repeat ($urandom_range(1, 6)) send_byte(pick_digit());
    end else if (kind < 62) begin
      send_byte(punct_chars[$urandom_range(8)]);
    end else if (kind < 74) begin
      case ($urandom_range(3))
        0:       send_text("==");
        1:       send_text("!=");
        2:       send_byte(CH_EQ);
        default: send_byte(CH_BANG);
      endcase
    end else if (kind < 86) begin
      send_byte(8'h20);
    end else if (kind < 96) begin
      send_byte(8'($urandom_range(1, 255)));
    end else begin
      send_byte(CH_NUL);
    end
  endtask

  // Hold the byte side idle until every predicted token has been seen; first
  // let the last byte's beat be sampled so its tokens are already predicted.
  task automatic drain_tokens();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (lexer_sb.pending() > 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int src_pct, input int sink_pct, input int count);
    int target;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    target         = bytes_sent + count;
    while (bytes_sent < target) send_snippet();
    drain_tokens();
  endtask

  initial begin
    #60ms;
    $display("TB_ERROR");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed text: keywords, all single-byte tokens, '!=', lone '!' and
    // '=', number running into a letter, a high byte ending a word, and a
    // zero byte flushing a pending '='.
    send_text("while(a!=9b){return=c,int;}+*%void!x");
    send_byte(8'hFF);
    send_byte(CH_EQ);
    send_byte(CH_NUL);
    drain_tokens();

    // Lengths around saturation, for identifiers and numbers.
    send_word(255, 1'b0);
    send_byte(8'h20);
    send_word(256, 1'b0);
    send_byte(CH_SEMI);
    send_word(257, 1'b1);
    send_byte(CH_NUL);
    drain_tokens();

    random_phase(0, 0, 235);
    random_phase(49, 0, 235);
    random_phase(0, 49, 235);
    random_phase(33, 33, 235);

    repeat (16) @(posedge clk_i);
    if (lexer_sb.errors == 0 && lexer_sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hdl
hdl/klex_pkg.sv
hdl/klex_core.sv
hdl/klex_fifo.sv
hdl/keyword_operator_lexer.sv
hdl/klex_checker.sv
sim/testbench.sv
